FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the pulse train generator RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/spg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spg_pkg
// Shared types and constants: register map, reset values, frame phase codes.
// ---------------------------------------------------------------------------
package spg_pkg;

   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ON = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 3'd6;

   // register reset values
   localparam logic [19:0] RST_FIRST_ON = 20'd300;
   localparam logic [19:0] RST_OFF      = 20'd1200;
   localparam logic [3:0]  RST_COUNT    = 4'd10;
   localparam logic [19:0] RST_IDLE     = 20'd5500;
   localparam logic [19:0] RST_SYNC     = 20'd50;
   localparam logic [19:0] RST_STEP     = 20'd50;
   localparam logic [23:0] RST_DEBOUNCE = 24'd250000;

   // frame phase codes
   localparam logic [1:0] PH_SYNC = 2'd0;
   localparam logic [1:0] PH_ON   = 2'd1;
   localparam logic [1:0] PH_OFF  = 2'd2;
   localparam logic [1:0] PH_IDLE = 2'd3;

   // on-time = first + (index - 1) * step fits in 25 bits
   localparam int ON_LEN_W  = 25;
   localparam int ON_PROD_W = 24;

   typedef struct packed {
      logic [19:0] first_on_ticks;
      logic [19:0] off_ticks;
      logic [3:0]  pulse_count;
      logic [19:0] idle_ticks;
      logic [19:0] sync_ticks;
      logic [19:0] step_ticks;
      logic [23:0] debounce_ticks;
   } cfg_type;

   // per-tick controls from the request stage into the frame sequencer
   typedef struct packed {
      logic step;
      logic enable_now;
      logic reverse_now;
   } seq_ctl_type;

endpackage

FILE: sv/spg_debounce.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spg_debounce
// Saturating elapsed counter and toggle flag for one button.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spg_debounce #(
   parameter int TIMER_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        press,
   input  logic [23:0] debounce_ticks,
   output logic        flag_now
);

   localparam int CMP_W = (TIMER_BITS > 24) ? TIMER_BITS : 24;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in, elapsed_sat;
   logic                  flag_ff, flag_in;
   logic                  taken;

   always_comb begin
      elapsed_sat = (elapsed_ff == TMAX) ? elapsed_ff : elapsed_ff + 1'b1;
      taken       = press && (CMP_W'(elapsed_sat) > CMP_W'(debounce_ticks));
      flag_now    = flag_ff ^ taken;
      if (step) begin
         elapsed_in = taken ? '0 : elapsed_sat;
         flag_in    = flag_now;
      end else begin
         elapsed_in = elapsed_ff;
         flag_in    = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         flag_ff    <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         flag_ff    <= flag_in;
      end
   end

   `ASSERT_CLK(a_flag_only_on_tick, clock, reset, !step |=> $stable(flag_ff), "flag moved without a tick")
   `ASSERT_CLK(a_toggle_clears, clock, reset, (step && taken) |=> (elapsed_ff == '0), "taken press did not clear counter")

endmodule

FILE: sv/spg_frame_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spg_frame_seq
// Frame phase sequencer: SYNC, data pulses ON/OFF, IDLE, normal or reverse.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spg_frame_seq #(
   parameter int TIMER_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  spg_pkg::seq_ctl_type ctl,
   input  spg_pkg::cfg_type    cfg,
   output logic                sync_level,
   output logic                data_level
);

   localparam int CMP_W = (TIMER_BITS > spg_pkg::ON_LEN_W) ? TIMER_BITS : spg_pkg::ON_LEN_W;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic [1:0]            phase_ff, phase_in;
   logic                  frame_reverse_ff, frame_reverse_in;
   logic [3:0]            pulse_index_ff, pulse_index_in;
   logic [3:0]            pulses_done_ff, pulses_done_in;
   logic [TIMER_BITS-1:0] phase_timer_ff, phase_timer_in;
   logic                  data_gate_ff, data_gate_in;

   logic [3:0]                     on_mul;
   logic [spg_pkg::ON_PROD_W-1:0]  on_prod;
   logic [spg_pkg::ON_LEN_W-1:0]   on_len, len_raw;
   logic [TIMER_BITS-1:0]          timer_inc;
   logic                           done;
   logic [3:0]                     pd_inc, idx_step;
   logic                           rv, goes_on, goes_on_idle;

   assign sync_level = (phase_ff == spg_pkg::PH_SYNC);
   assign data_level = (phase_ff == spg_pkg::PH_ON) && data_gate_ff;

   // phase length; zero lengths and lengths past the timer range fall out of the compare
   always_comb begin
      on_mul  = (pulse_index_ff == 4'd0) ? 4'd0 : pulse_index_ff - 4'd1;
      on_prod = spg_pkg::ON_PROD_W'(on_mul) * spg_pkg::ON_PROD_W'(cfg.step_ticks);
      on_len  = spg_pkg::ON_LEN_W'(cfg.first_on_ticks) + spg_pkg::ON_LEN_W'(on_prod);
      unique case (phase_ff)
         spg_pkg::PH_SYNC: len_raw = spg_pkg::ON_LEN_W'(cfg.sync_ticks);
         spg_pkg::PH_ON:   len_raw = on_len;
         spg_pkg::PH_OFF:  len_raw = spg_pkg::ON_LEN_W'(cfg.off_ticks);
         default:          len_raw = spg_pkg::ON_LEN_W'(cfg.idle_ticks);
      endcase
      timer_inc = phase_timer_ff + 1'b1;
      done      = (CMP_W'(timer_inc) >= CMP_W'(len_raw)) || (timer_inc == TMAX);
   end

   always_comb begin
      rv       = ctl.reverse_now;
      pd_inc   = pulses_done_ff + 4'd1;
      if (rv) begin
         idx_step = (pulse_index_ff == 4'd0) ? 4'd0 : pulse_index_ff - 4'd1;
      end else begin
         idx_step = (pulse_index_ff == 4'd15) ? 4'd15 : pulse_index_ff + 4'd1;
      end
      goes_on      = (pd_inc < cfg.pulse_count) && (rv == frame_reverse_ff);
      goes_on_idle = (pulses_done_ff < cfg.pulse_count) && (rv == frame_reverse_ff);

      phase_in         = phase_ff;
      frame_reverse_in = frame_reverse_ff;
      pulse_index_in   = pulse_index_ff;
      pulses_done_in   = pulses_done_ff;
      phase_timer_in   = phase_timer_ff;
      data_gate_in     = data_gate_ff;

      if (ctl.step) begin
         phase_timer_in = done ? '0 : timer_inc;
         if (done) begin
            unique case (phase_ff)
               spg_pkg::PH_SYNC: begin
                  frame_reverse_in = rv;
                  pulses_done_in   = 4'd0;
                  if (rv) begin
                     pulse_index_in = cfg.pulse_count;
                     phase_in       = spg_pkg::PH_IDLE;
                  end else begin
                     pulse_index_in = 4'd1;
                     if (cfg.pulse_count != 4'd0) begin
                        phase_in     = spg_pkg::PH_ON;
                        data_gate_in = ctl.enable_now;
                     end else begin
                        phase_in = spg_pkg::PH_IDLE;
                     end
                  end
               end
               spg_pkg::PH_ON: begin
                  if (!frame_reverse_ff) begin
                     phase_in = spg_pkg::PH_OFF;
                  end else begin
                     pulses_done_in = pd_inc;
                     pulse_index_in = idx_step;
                     phase_in       = goes_on ? spg_pkg::PH_OFF : spg_pkg::PH_SYNC;
                  end
               end
               spg_pkg::PH_OFF: begin
                  if (frame_reverse_ff) begin
                     phase_in     = spg_pkg::PH_ON;
                     data_gate_in = ctl.enable_now;
                  end else begin
                     pulses_done_in = pd_inc;
                     pulse_index_in = idx_step;
                     if (goes_on) begin
                        phase_in     = spg_pkg::PH_ON;
                        data_gate_in = ctl.enable_now;
                     end else begin
                        phase_in = spg_pkg::PH_IDLE;
                     end
                  end
               end
               default: begin
                  if (frame_reverse_ff && goes_on_idle) phase_in = spg_pkg::PH_OFF;
                  else phase_in = spg_pkg::PH_SYNC;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= spg_pkg::PH_SYNC;
         frame_reverse_ff <= 1'b0;
         pulse_index_ff   <= 4'd1;
         pulses_done_ff   <= 4'd0;
         phase_timer_ff   <= '0;
         data_gate_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         frame_reverse_ff <= frame_reverse_in;
         pulse_index_ff   <= pulse_index_in;
         pulses_done_ff   <= pulses_done_in;
         phase_timer_ff   <= phase_timer_in;
         data_gate_ff     <= data_gate_in;
      end
   end

   `ASSERT_NEVER(a_timer_below_max, clock, reset, phase_timer_ff == TMAX, "phase timer reached its maximum")
   `ASSERT_CLK(a_phase_only_on_tick, clock, reset, !ctl.step |=> $stable(phase_ff), "phase moved without a tick")

endmodule

FILE: sv/sync_pulse_train_generator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_pulse_train_generator
// SYNC/DATA pulse train generator with debounced enable and mode buttons.
// ---------------------------------------------------------------------------
// Path: a request accepted at a clock edge passes through the request
//   register, then the response register, before its response is offered.
// Throughput: one request per cycle; the request register drains into the
//   response register whenever that register is empty or being taken.
// Reset: synchronous, active high; the settings registers return to their default values,
//   both flags clear and the frame restarts in its SYNC phase.

`include "assert_macros.svh"

module sync_pulse_train_generator #(
   parameter int TIMER_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel: one timebase tick with two button events
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_enable_press,
   input  logic                             req_select_press,
   // response channel: line levels and flags for that tick
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_sync_level,
   output logic                             rsp_data_level,
   output logic                             rsp_enabled,
   output logic                             rsp_reverse_active,
   // register write port
   input  logic                             csr_write_enable,
   input  logic [spg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   spg_pkg::cfg_type     cfg_ff;
   spg_pkg::seq_ctl_type seq_ctl;

   logic in_valid_ff, in_enable_ff, in_select_ff;
   logic rsp_valid_ff;
   logic rsp_sync_ff, rsp_data_ff, rsp_enabled_ff, rsp_reverse_ff;
   logic advance;
   logic enable_now, reverse_now;
   logic sync_level, data_level;

   // ---- register file: plain writes, unknown indexes are dropped ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_on_ticks <= spg_pkg::RST_FIRST_ON;
         cfg_ff.off_ticks      <= spg_pkg::RST_OFF;
         cfg_ff.pulse_count    <= spg_pkg::RST_COUNT;
         cfg_ff.idle_ticks     <= spg_pkg::RST_IDLE;
         cfg_ff.sync_ticks     <= spg_pkg::RST_SYNC;
         cfg_ff.step_ticks     <= spg_pkg::RST_STEP;
         cfg_ff.debounce_ticks <= spg_pkg::RST_DEBOUNCE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            spg_pkg::CSR_FIRST_ON: cfg_ff.first_on_ticks <= csr_wdata[19:0];
            spg_pkg::CSR_OFF:      cfg_ff.off_ticks      <= csr_wdata[19:0];
            spg_pkg::CSR_COUNT:    cfg_ff.pulse_count    <= csr_wdata[3:0];
            spg_pkg::CSR_IDLE:     cfg_ff.idle_ticks     <= csr_wdata[19:0];
            spg_pkg::CSR_SYNC:     cfg_ff.sync_ticks     <= csr_wdata[19:0];
            spg_pkg::CSR_STEP:     cfg_ff.step_ticks     <= csr_wdata[19:0];
            spg_pkg::CSR_DEBOUNCE: cfg_ff.debounce_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- request register ----
   // Advance the held request whenever the response slot is free or drains.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload: hold while stalled, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_enable_ff <= req_enable_press;
         in_select_ff <= req_select_press;
      end
   end

   // ---- tick work: debounce both buttons, then step the frame ----
   spg_debounce #(.TIMER_BITS(TIMER_BITS)) u_enable_db (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .press          (in_enable_ff),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .flag_now       (enable_now)
   );

   spg_debounce #(.TIMER_BITS(TIMER_BITS)) u_select_db (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .press          (in_select_ff),
      .debounce_ticks (cfg_ff.debounce_ticks),
      .flag_now       (reverse_now)
   );

   // the sequencer sees the flags as updated by this tick's presses
   assign seq_ctl.step        = advance;
   assign seq_ctl.enable_now  = enable_now;
   assign seq_ctl.reverse_now = reverse_now;

   spg_frame_seq #(.TIMER_BITS(TIMER_BITS)) u_frame_seq (
      .clock      (clock),
      .reset      (reset),
      .ctl        (seq_ctl),
      .cfg        (cfg_ff),
      .sync_level (sync_level),
      .data_level (data_level)
   );

   // ---- response register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // levels come from the phase in force during the tick, flags after presses
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sync_ff    <= sync_level;
         rsp_data_ff    <= data_level;
         rsp_enabled_ff <= enable_now;
         rsp_reverse_ff <= reverse_now;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sync_level     = rsp_sync_ff;
   assign rsp_data_level     = rsp_data_ff;
   assign rsp_enabled        = rsp_enabled_ff;
   assign rsp_reverse_active = rsp_reverse_ff;

   // a held request must survive a stalled response slot
   `ASSERT_CLK(a_hold_request, clock, reset, (in_valid_ff && !advance) |=> in_valid_ff, "held request dropped")
   `ASSERT_CLK(a_advance_fills_rsp, clock, reset, advance |=> rsp_valid_ff, "advanced request produced no response")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - sync_pulse_train_generator testbench
// Runs a cycle-true software copy of the frame sequencer and the button
// debouncers, predicts the line levels and flags of every tick request, and
// checks each response against the oldest prediction. Requests arrive in
// bursts with gaps and the receiver stalls on its own pattern. The register
// settings change between phases: reset values, the shortest legal timings,
// the longest ones, then a series of short random frames.
// ----------------------------------------------------------------------------
module tb;

   localparam int TIMER_BITS = 24;
   localparam longint unsigned TICK_MAX = (64'd1 << TIMER_BITS) - 64'd1;
   localparam int STALL_LIMIT = 2000;  // cycles with no request or response moving
   localparam int LONG_HOLD = 120;     // receiver hold-off, long enough to back up requests
   localparam int DRAIN_CYCLES = 4;    // request and response registers, with margin
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PHASES = 8;

   // line levels and flags carried by one response
   typedef struct packed {
      logic sync_level;
      logic data_level;
      logic enabled;
      logic reverse_active;
   } tick_levels_type;

   typedef enum {READY_ALWAYS, READY_COIN, READY_CADENCE, READY_MOSTLY} ready_pattern_type;

   // -------------------------------------------------------------------------
   // Scoreboard: advances its own copy of the sequencer for every accepted
   // tick request and keeps the predicted levels until the response arrives.
   // -------------------------------------------------------------------------
   class pulse_train_scoreboard;
      spg_pkg::cfg_type settings;
      bit enable_flag, reverse_flag, frame_reverse, data_gate;
      longint unsigned enable_age, select_age, phase_age;
      logic [1:0] phase;
      int unsigned pulse_index, pulses_done;
      tick_levels_type levels_q[$];
      int unsigned ticks, checked, errors;
      int unsigned enable_toggles, mode_toggles, frames, reverse_frames;

      function new();
         settings = '{spg_pkg::RST_FIRST_ON, spg_pkg::RST_OFF, spg_pkg::RST_COUNT,
                      spg_pkg::RST_IDLE, spg_pkg::RST_SYNC, spg_pkg::RST_STEP,
                      spg_pkg::RST_DEBOUNCE};
         enable_flag = 1'b0;
         reverse_flag = 1'b0;
         frame_reverse = 1'b0;
         data_gate = 1'b0;
         enable_age = 0;
         select_age = 0;
         phase_age = 0;
         phase = spg_pkg::PH_SYNC;
         pulse_index = 1;
         pulses_done = 0;
         ticks = 0;
         checked = 0;
         errors = 0;
         enable_toggles = 0;
         mode_toggles = 0;
         frames = 0;
         reverse_frames = 0;
      endfunction

      // length of the current phase in ticks, never zero, never past the timer
      function longint unsigned phase_span();
         longint unsigned span, steps;
         steps = (pulse_index > 0) ? longint'(pulse_index - 1) : 64'd0;
         case (phase)
            spg_pkg::PH_SYNC: span = longint'(settings.sync_ticks);
            spg_pkg::PH_ON:   span = longint'(settings.first_on_ticks)
                                     + steps * longint'(settings.step_ticks);
            spg_pkg::PH_OFF:  span = longint'(settings.off_ticks);
            default:          span = longint'(settings.idle_ticks);
         endcase
         if (span > TICK_MAX) span = TICK_MAX;
         if (span == 0) span = 1;
         return span;
      endfunction

      // the index follows the live mode, not the frame direction
      function void advance_index();
         pulses_done = (pulses_done + 1) & 15;
         if (!reverse_flag) begin
            if (pulse_index < 15) pulse_index++;
         end else begin
            if (pulse_index > 0) pulse_index--;
         end
      endfunction

      function bit loop_continues();
         return pulses_done < int'(settings.pulse_count) && reverse_flag == frame_reverse;
      endfunction

      function void start_on();
         phase = spg_pkg::PH_ON;
         data_gate = enable_flag;
      endfunction

      function void close_phase();
         case (phase)
            spg_pkg::PH_SYNC: begin
               frame_reverse = reverse_flag;
               pulses_done = 0;
               frames++;
               if (frame_reverse) begin
                  reverse_frames++;
                  pulse_index = int'(settings.pulse_count);
                  phase = spg_pkg::PH_IDLE;
               end else begin
                  pulse_index = 1;
                  if (loop_continues()) start_on();
                  else phase = spg_pkg::PH_IDLE;
               end
            end
            spg_pkg::PH_ON: begin
               if (!frame_reverse) begin
                  phase = spg_pkg::PH_OFF;
               end else begin
                  advance_index();
                  phase = loop_continues() ? spg_pkg::PH_OFF : spg_pkg::PH_SYNC;
               end
            end
            spg_pkg::PH_OFF: begin
               if (frame_reverse) begin
                  start_on();
               end else begin
                  advance_index();
                  if (loop_continues()) start_on();
                  else phase = spg_pkg::PH_IDLE;
               end
            end
            default: phase = (frame_reverse && loop_continues()) ? spg_pkg::PH_OFF
                                                                 : spg_pkg::PH_SYNC;
         endcase
      endfunction

      function void note_request(logic enable_press, logic select_press);
         tick_levels_type levels;
         ticks++;
         if (enable_age < TICK_MAX) enable_age++;
         if (select_age < TICK_MAX) select_age++;
         if (enable_press && enable_age > longint'(settings.debounce_ticks)) begin
            enable_flag = !enable_flag;
            enable_age = 0;
            enable_toggles++;
         end
         if (select_press && select_age > longint'(settings.debounce_ticks)) begin
            reverse_flag = !reverse_flag;
            select_age = 0;
            mode_toggles++;
         end
         levels.sync_level = (phase == spg_pkg::PH_SYNC);
         levels.data_level = (phase == spg_pkg::PH_ON) && data_gate;
         levels.enabled = enable_flag;
         levels.reverse_active = reverse_flag;
         levels_q.push_back(levels);
         phase_age++;
         if (phase_age >= phase_span()) begin
            phase_age = 0;
            close_phase();
         end
      endfunction

      function void check_result(tick_levels_type got);
         tick_levels_type want;
         checked++;
         if (levels_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("response %0d arrived with no prediction waiting", checked);
            return;
         end
         want = levels_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("response %0d: expected sync=%b data=%b en=%b rev=%b, got %b %b %b %b",
                        checked, want.sync_level, want.data_level, want.enabled,
                        want.reverse_active, got.sync_level, got.data_level, got.enabled,
                        got.reverse_active);
         end
      endfunction

      function int unsigned pending();
         return levels_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, ports, block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_enable_press = 1'b0;
   logic req_select_press = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_sync_level, rsp_data_level, rsp_enabled, rsp_reverse_active;
   logic csr_write_enable = 1'b0;
   logic [spg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [spg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pulse_train_scoreboard sb;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sync_pulse_train_generator #(.TIMER_BITS(TIMER_BITS)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_enable_press   (req_enable_press),
      .req_select_press   (req_select_press),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sync_level     (rsp_sync_level),
      .rsp_data_level     (rsp_data_level),
      .rsp_enabled        (rsp_enabled),
      .rsp_reverse_active (rsp_reverse_active),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Monitor: note the accepted request before checking the response of the
   // same edge, so the prediction is always in place first.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_enable_press, req_select_press);
         if (rsp_valid && rsp_ready)
            sb.check_result(tick_levels_type'({rsp_sync_level, rsp_data_level, rsp_enabled,
                                               rsp_reverse_active}));
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: pick a new random stall pattern each time pattern_age wraps; after 200
   // responses and every 500 after that, hold off for LONG_HOLD so the block backs up.
   // -------------------------------------------------------------------------
   int unsigned rsp_taken = 0;
   int unsigned hold_left = 0;
   int unsigned next_hold = 200;
   int unsigned pattern_age = 0;
   ready_pattern_type ready_pattern = READY_ALWAYS;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) rsp_taken++;
      pattern_age++;
      if (pattern_age >= 64) begin
         pattern_age = 0;
         ready_pattern = ready_pattern_type'($urandom_range(0, 3));
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_taken >= next_hold) begin
         hold_left = LONG_HOLD;
         next_hold += 500;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_pattern)
            READY_ALWAYS:  rsp_ready <= 1'b1;
            READY_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
            READY_CADENCE: rsp_ready <= (pattern_age % 3) != 0;
            default:       rsp_ready <= $urandom_range(0, 7) != 0;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run when the count of cycles in which nothing has moved
   // on either channel reaches STALL_LIMIT.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("no request or response moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------

   // Offer one tick request and hold it until accepted. Valid stays high when
   // the caller offers the next request straight away.
   task automatic send_tick(input logic enable_press, input logic select_press);
      req_valid <= 1'b1;
      req_enable_press <= enable_press;
      req_select_press <= select_press;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_requests(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted response has been taken, so
   // both pipeline registers are empty; come back on a rising edge. Look at
   // the queue only after a falling edge, once the monitor has noted the
   // request accepted at the edge we were called on.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   // Write all seven registers on back-to-back edges while the block is idle.
   task automatic program_regs(input spg_pkg::cfg_type c);
      logic [spg_pkg::CSR_IDX_W-1:0] reg_index [7];
      logic [spg_pkg::CSR_DATA_W-1:0] reg_value [7];
      reg_index = '{spg_pkg::CSR_FIRST_ON, spg_pkg::CSR_OFF, spg_pkg::CSR_COUNT,
                    spg_pkg::CSR_IDLE, spg_pkg::CSR_SYNC, spg_pkg::CSR_STEP,
                    spg_pkg::CSR_DEBOUNCE};
      reg_value = '{spg_pkg::CSR_DATA_W'(c.first_on_ticks),
                    spg_pkg::CSR_DATA_W'(c.off_ticks),
                    spg_pkg::CSR_DATA_W'(c.pulse_count),
                    spg_pkg::CSR_DATA_W'(c.idle_ticks),
                    spg_pkg::CSR_DATA_W'(c.sync_ticks),
                    spg_pkg::CSR_DATA_W'(c.step_ticks),
                    spg_pkg::CSR_DATA_W'(c.debounce_ticks)};
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= reg_index[i];
         csr_wdata <= reg_value[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      sb.settings = c;
   endtask

   // Short frames so a few hundred ticks walk through many of them.
   function automatic spg_pkg::cfg_type random_settings();
      spg_pkg::cfg_type c;
      c.first_on_ticks = 20'($urandom_range(1, 6));
      c.off_ticks = 20'($urandom_range(1, 4));
      c.pulse_count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(7, 15))
                                                  : 4'($urandom_range(1, 6));
      c.idle_ticks = 20'($urandom_range(0, 6));
      c.sync_ticks = 20'($urandom_range(1, 4));
      c.step_ticks = 20'($urandom_range(0, 3));
      c.debounce_ticks = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(50, 300))
                                                     : 24'($urandom_range(0, 40));
      return c;
   endfunction

   // Bursts of random length; each button is left unpressed in about half of them
   // so frames can run to the end, else it is pressed at a random density. Most bursts end
   // in a gap, some run straight into the next.
   task automatic run_random_ticks(input int unsigned count);
      int unsigned sent, burst, enable_weight, select_weight;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         enable_weight = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
         select_weight = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
         for (int b = 0; b < burst && sent < count; b++) begin
            send_tick($urandom_range(0, 15) < enable_weight,
                      $urandom_range(0, 15) < select_weight);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 8));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      spg_pkg::cfg_type c;
      int unsigned settings_used;
      logic [1:0] fast_presses [12];
      logic [1:0] slow_presses [6];
      fast_presses = '{2'b10, 2'b00, 2'b01, 2'b00, 2'b11, 2'b00,
                       2'b00, 2'b01, 2'b10, 2'b00, 2'b00, 2'b11};
      slow_presses = '{2'b11, 2'b00, 2'b10, 2'b01, 2'b00, 2'b11};
      sb = new();
      settings_used = 1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset values: the debounce window is far longer than the run, so
      // every press is rejected and the frame sits in SYNC.
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      drain_responses();

      // Shortest timings: one-tick phases, zero idle, zero step, one pulse,
      // and no debounce so every press toggles its flag.
      c = '{20'd1, 20'd1, 4'd1, 20'd0, 20'd1, 20'd0, 24'd0};
      program_regs(c);
      settings_used++;
      foreach (fast_presses[i]) send_tick(fast_presses[i][1], fast_presses[i][0]);
      drain_responses();

      // Longest timings and a saturated debounce: no press is ever taken.
      c = '{20'hFFFFF, 20'hFFFFF, 4'd15, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF};
      program_regs(c);
      settings_used++;
      foreach (slow_presses[i]) send_tick(slow_presses[i][1], slow_presses[i][0]);
      drain_responses();

      // Random phases; force a frame with no data pulses in the first and a
      // full fifteen pulses in the second. Drain fully before each rewrite.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         c = random_settings();
         if (p == 0) c.pulse_count = 4'd0;
         if (p == 1) c.pulse_count = 4'd15;
         program_regs(c);
         settings_used++;
         run_random_ticks($urandom_range(140, 170));
         drain_responses();
      end

      // Let any stray response show up, then count leftovers as failures.
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      sb.errors += sb.pending();

      $display("Checked %0d tick responses under %0d register settings; %0d frames, %0d reverse.",
               sb.checked, settings_used, sb.frames, sb.reverse_frames);
      $display("Debounced presses taken: %0d enable, %0d mode select; %0d errors.",
               sb.enable_toggles, sb.mode_toggles, sb.errors);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
